[hdl/assert_macros.svh]
// Assertion macros shared by the surface charge colorizer RTL.
// Included by the files that carry concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: %m");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

[hdl/scc_pkg.sv]
// Package for the surface charge colorizer: payload types, register codes,
// controller states, command/status bundles and the exp2 table generator.
`timescale 1ns / 1ps

package scc_pkg;

  // Default sizes
  localparam int MAX_ATOMS_DEF       = 4096;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  // Field widths
  localparam int COORD_W    = 24;
  localparam int RAD_W      = 12;
  localparam int CHG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_OUT_W  = 13;

  // Arithmetic constants
  localparam int LOG2E_Q16  = 94548;
  localparam int LN2_Q30    = 744261118;
  localparam int T_LIMIT    = 64 * 4096;
  localparam int CHARGE_MAX = 8388607;
  localparam int CHARGE_MIN = -8388608;

  // Shared divider: numerator magnitude, divisor, quotient bits
  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_Q_W   = 20;

  // Width of one gaussian term after the exponent shift
  localparam int TERM_W = 41;

  // Register reset values
  localparam logic                         MODE_RST   = 1'b0;
  localparam logic [CFG_DATA_W-1:0]        CUTOFF_RST = 16'd2560;
  localparam logic signed [CFG_DATA_W-1:0] BLOB_RST   = -16'sd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_CUTOFF = 2'd1,
    CFG_BLOB   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    MODE_GAUSS = 1'b0,
    MODE_AVG   = 1'b1
  } mode_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [RAD_W-1:0]          atom_radius;
    logic signed [CHG_W-1:0]   atom_charge;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0]      vertex_charge;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic [CNT_OUT_W-1:0]    neighbor_count;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [RAD_W-1:0]          atom_radius;
    logic signed [CHG_W-1:0]   atom_charge;
  } atom_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_SQUARE,
    S_CHECK,
    S_DECIDE,
    S_TSTART,
    S_TDIV,
    S_EXPK,
    S_EMUL,
    S_ACCUM,
    S_NEXT,
    S_AVG_START,
    S_AVG_DIV,
    S_SATURATE,
    S_COLOR
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_atom;
    logic latch_vtx;
    logic rd_en;
    logic sq_en;
    logic cmp_en;
    logic cnt_inc;
    logic acc_charge;
    logic prod_en;
    logic div_start;
    logic div_avg;
    logic exp1_en;
    logic exp2_en;
    logic exp3_en;
    logic acc_term;
    logic idx_inc;
    logic avg_take;
    logic sat_en;
    logic out_en;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  in_range;
    mode_e mode;
    logic  last_atom;
    logic  empty;
    logic  cnt_zero;
    logic  div_done;
  } sts_t;

  // 2^(k/depth) in Q.16 from x = k*ln2/depth in Q.30, by a power series up to the 30th power
  function automatic logic [16:0] exp2_entry(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int i = 1; i <= 30; i++) begin
      term = ((term * x) >> 30) / 64'(i);
      sum  = sum + term;
    end
    return 17'((sum + 64'd8192) >> 14);
  endfunction

endpackage

[hdl/surface_charge_colorizer.sv]
// Load: stored from the idle state, no result. A query walks every stored atom in turn
// through the single-port store; in gauss mode each atom within the cutoff, and in average
// mode the final mean when there are neighbors, waits on the shared divider. An empty store
// goes straight to saturation. One query at a time; the strobe lasts one cycle and cannot
// be stalled.
// Reset is asynchronous, active low, empties the store count and restores register defaults.
`timescale 1ns / 1ps

module surface_charge_colorizer #(
  parameter int MAX_ATOMS       = scc_pkg::MAX_ATOMS_DEF,
  parameter int EXP_TABLE_DEPTH = scc_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  scc_pkg::in_item_t               in_i,
  output logic                            done_o,
  output scc_pkg::out_item_t              result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  scc_pkg::cmd_t cmd;
  scc_pkg::sts_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  scc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (in_i.operation),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  scc_datapath #(
    .MAX_ATOMS       (MAX_ATOMS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule

[hdl/scc_div.sv]
// Restoring divider shared by the exponent argument and the neighbor average.
// One quotient bit per cycle; depends on scc_pkg for widths.
`timescale 1ns / 1ps

module scc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [scc_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [scc_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                            done_o,
  output logic [scc_pkg::DIV_Q_W-1:0]     quot_o,
  output logic                            ovf_o
);

  localparam int NW = scc_pkg::DIV_NUM_W;
  localparam int QW = scc_pkg::DIV_Q_W;
  localparam int CTW = $clog2(QW);

  logic [NW-1:0]  rem_q, rem_d;
  logic [NW-1:0]  dsh_q, dsh_d;
  logic [QW-1:0]  quot_q, quot_d;
  logic           ovf_q, ovf_d;
  logic [CTW-1:0] cnt_q, cnt_d;
  logic           run_q, run_d;
  logic           done_q, done_d;
  logic           fits;

  // One restoring step per cycle, most significant quotient bit first
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    fits   = rem_q >= dsh_q;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = NW'(den_i) << (QW - 1);
      quot_d = '0;
      ovf_d  = num_i >= (NW'(den_i) << QW);
      cnt_d  = CTW'(QW - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[QW-2:0], fits};
      dsh_d  = dsh_q >> 1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

[hdl/scc_datapath.sv]
// Datapath: configuration registers, atom store, distance, exponent and
// accumulate stages, color mapping. Depends on scc_pkg and scc_div.
`timescale 1ns / 1ps

module scc_datapath #(
  parameter int MAX_ATOMS       = scc_pkg::MAX_ATOMS_DEF,
  parameter int EXP_TABLE_DEPTH = scc_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scc_pkg::in_item_t                 in_i,
  input  logic                              cfg_valid_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  scc_pkg::cmd_t                     cmd_i,
  output scc_pkg::sts_t                     sts_o,
  output scc_pkg::out_item_t                result_o
);

  localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW    = $clog2(MAX_ATOMS + 1);
  localparam int KW    = $clog2(EXP_TABLE_DEPTH);
  localparam int ACC_W = scc_pkg::TERM_W + CW;
  localparam int NW    = scc_pkg::DIV_NUM_W;
  localparam int QW    = scc_pkg::DIV_Q_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(scc_pkg::CHARGE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(scc_pkg::CHARGE_MIN);

  // Channel value for a charge magnitude, with the clamp flag on top
  function automatic logic [8:0] chan(input logic [23:0] mag);
    logic [13:0] diff;
    logic [21:0] prod;
    diff = 14'd0;
    prod = 22'd0;
    if (mag > 24'd8192) begin
      return {1'b1, 8'd0};
    end
    diff = 14'd8192 - mag[13:0];
    prod = 22'(diff) * 22'd255 + 22'd4096;
    return {1'b0, prod[20:13]};
  endfunction

  // exp2 fraction table, built at elaboration
  logic [16:0] exp_tbl [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam logic [63:0] XARG =
      (64'(g) * 64'(scc_pkg::LN2_Q30)) / 64'(EXP_TABLE_DEPTH);
    localparam logic [16:0] ENTRY = scc_pkg::exp2_entry(XARG);
    assign exp_tbl[g] = ENTRY;
  end

  // Configuration registers
  logic                                mode_q;
  logic [scc_pkg::CFG_DATA_W-1:0]      cutoff_q;
  logic signed [scc_pkg::CFG_DATA_W-1:0] blob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= scc_pkg::MODE_RST;
      cutoff_q <= scc_pkg::CUTOFF_RST;
      blob_q   <= scc_pkg::BLOB_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        scc_pkg::CFG_MODE:   mode_q   <= cfg_data_i[0];
        scc_pkg::CFG_CUTOFF: cutoff_q <= cfg_data_i;
        scc_pkg::CFG_BLOB:   blob_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Atom store and fill count
  scc_pkg::atom_t mem_q [MAX_ATOMS];
  scc_pkg::atom_t rd_q;
  scc_pkg::atom_t wr_atom;
  logic [CW-1:0]  loaded_q;
  logic [AW-1:0]  idx_q;
  logic           full;

  assign full = loaded_q == CW'(MAX_ATOMS);
  assign wr_atom = '{pos_x: in_i.pos_x, pos_y: in_i.pos_y, pos_z: in_i.pos_z,
                     atom_radius: in_i.atom_radius, atom_charge: in_i.atom_charge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_atom && !full) begin
      mem_q[loaded_q[AW-1:0]] <= wr_atom;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.load_atom && !full) begin
        loaded_q <= loaded_q + 1'b1;
      end
      if (cmd_i.latch_vtx) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Vertex latch
  logic signed [23:0] vx_q, vy_q, vz_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_vtx) begin
      vx_q <= in_i.pos_x;
      vy_q <= in_i.pos_y;
      vz_q <= in_i.pos_z;
    end
  end

  // Squares of the offsets and of the radius
  logic signed [24:0] dx, dy, dz;
  logic signed [49:0] sqx_d, sqy_d, sqz_d;
  logic [49:0]        sqx_q, sqy_q, sqz_q;
  logic [11:0]        rad;
  logic [23:0]        r2_d, r2_q;

  always_comb begin
    dx    = {vx_q[23], vx_q} - {rd_q.pos_x[23], rd_q.pos_x};
    dy    = {vy_q[23], vy_q} - {rd_q.pos_y[23], rd_q.pos_y};
    dz    = {vz_q[23], vz_q} - {rd_q.pos_z[23], rd_q.pos_z};
    sqx_d = dx * dx;
    sqy_d = dy * dy;
    sqz_d = dz * dz;
    rad   = (rd_q.atom_radius == '0) ? 12'd1 : rd_q.atom_radius;
    r2_d  = rad * rad;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
      r2_q  <= r2_d;
    end
  end

  // Sum of squares against the cutoff (inclusive)
  logic [51:0] d2;
  logic [31:0] cut2;
  logic [31:0] d2_q;
  logic        in_range_q;

  always_comb begin
    d2   = {2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q};
    cut2 = cutoff_q * cutoff_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      in_range_q <= d2 <= {20'b0, cut2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      d2_q <= d2[31:0];
    end
  end

  // Numerator of the exponent argument: b * (d2 - r2)
  logic signed [32:0] diff;
  logic signed [48:0] prod_d, prod_q;

  always_comb begin
    diff   = $signed({1'b0, d2_q}) - $signed({9'b0, r2_q});
    prod_d = blob_q * diff;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_q <= prod_d;
    end
  end

  // Shared divider
  logic signed [ACC_W-1:0]  acc_q;
  logic [CW-1:0]            cnt_q;
  logic [NW-1:0]            prod_mag;
  logic [ACC_W-1:0]         acc_mag;
  logic [NW-1:0]            div_num;
  logic [scc_pkg::DIV_DEN_W-1:0] div_den;
  logic                     div_done;
  logic [QW-1:0]            div_quot;
  logic                     div_ovf;

  always_comb begin
    prod_mag = prod_q[48] ? -prod_q : prod_q;
    acc_mag  = acc_q[ACC_W-1] ? -acc_q : acc_q;
    div_num  = cmd_i.div_avg ? NW'(acc_mag) : prod_mag;
    div_den  = cmd_i.div_avg ? scc_pkg::DIV_DEN_W'(cnt_q) : r2_q;
  end

  scc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .ovf_o   (div_ovf)
  );

  // Exponent argument to base 2: u = floor(t * log2(e))
  logic [QW-1:0]      qc;
  logic signed [19:0] t_val;
  logic signed [37:0] tl;
  logic signed [25:0] u_q;

  always_comb begin
    qc    = (div_ovf || div_quot > QW'(scc_pkg::T_LIMIT)) ?
            QW'(scc_pkg::T_LIMIT) : div_quot;
    t_val = prod_q[48] ? -qc : qc;
    tl    = t_val * 38'(scc_pkg::LOG2E_Q16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp1_en) begin
      u_q <= 26'(tl >>> 12);
    end
  end

  // Split into integer and fraction, look up the fraction
  logic signed [9:0] n_int;
  logic [9:0]        n_neg;
  logic [31:0]       k_full;
  logic [KW-1:0]     k_idx;
  logic [16:0]       entry;
  logic [16:0]       es_d, es_q;
  logic [4:0]        sh_d, sh_q;
  logic              zero_d, zero_q;

  always_comb begin
    n_int  = u_q[25:16];
    n_neg  = -n_int;
    k_full = (32'(u_q[15:0]) * 32'(EXP_TABLE_DEPTH)) >> 16;
    k_idx  = k_full[KW-1:0];
    entry  = exp_tbl[k_idx];
    es_d   = entry;
    sh_d   = 5'd0;
    zero_d = 1'b0;
    if (n_int > 10'sd23) begin
      es_d = exp_tbl[EXP_TABLE_DEPTH-1];
      sh_d = 5'd23;
    end else if (n_int < -10'sd32) begin
      es_d   = '0;
      zero_d = 1'b1;
    end else if (n_int >= 10'sd0) begin
      sh_d = n_int[4:0];
    end else begin
      es_d = entry >> n_neg[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp2_en) begin
      es_q   <= es_d;
      sh_q   <= sh_d;
      zero_q <= zero_d;
    end
  end

  // Charge times mantissa
  logic signed [33:0] p_d, p_q;
  assign p_d = rd_q.atom_charge * $signed({1'b0, es_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp3_en) begin
      p_q <= p_d;
    end
  end

  // Apply the exponent and accumulate
  logic signed [56:0]              pw;
  logic signed [56:0]              pshift;
  logic signed [scc_pkg::TERM_W-1:0] term;
  logic signed [ACC_W-1:0]         term_ext;
  logic signed [ACC_W-1:0]         chg_ext;
  logic [ACC_W-1:0]                quot_ext;
  logic signed [ACC_W-1:0]         avg_val;

  always_comb begin
    pw       = p_q;
    pshift   = (pw <<< sh_q) >>> 16;
    term     = zero_q ? '0 : pshift[scc_pkg::TERM_W-1:0];
    term_ext = term;
    chg_ext  = rd_q.atom_charge;
    quot_ext = ACC_W'(div_quot);
    avg_val  = acc_q[ACC_W-1] ? -quot_ext : quot_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.latch_vtx) begin
        acc_q <= '0;
      end else if (cmd_i.acc_term) begin
        acc_q <= acc_q + term_ext;
      end else if (cmd_i.acc_charge) begin
        acc_q <= acc_q + chg_ext;
      end else if (cmd_i.avg_take) begin
        acc_q <= avg_val;
      end
      if (cmd_i.latch_vtx) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Saturate the charge
  logic signed [23:0] c_q;
  logic               csat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sat_en) begin
      if (acc_q > ACC_MAX) begin
        c_q    <= 24'sd8388607;
        csat_q <= 1'b1;
      end else if (acc_q < ACC_MIN) begin
        c_q    <= -24'sd8388608;
        csat_q <= 1'b1;
      end else begin
        c_q    <= acc_q[23:0];
        csat_q <= 1'b0;
      end
    end
  end

  // Map to color and hold the result
  logic [23:0]         cmag;
  logic [8:0]          ch;
  scc_pkg::out_item_t  res_d, res_q;

  always_comb begin
    cmag                 = c_q[23] ? -c_q : c_q;
    ch                   = chan(cmag);
    res_d.vertex_charge  = c_q;
    res_d.red            = 8'd255;
    res_d.green          = 8'd255;
    res_d.blue           = 8'd255;
    res_d.neighbor_count = scc_pkg::CNT_OUT_W'(cnt_q);
    res_d.saturated      = csat_q;
    if (c_q < 24'sd0) begin
      res_d.green     = ch[7:0];
      res_d.blue      = ch[7:0];
      res_d.saturated = csat_q | ch[8];
    end else if (c_q > 24'sd0) begin
      res_d.red       = ch[7:0];
      res_d.green     = ch[7:0];
      res_d.saturated = csat_q | ch[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

  // Status back to the controller
  always_comb begin
    sts_o.in_range  = in_range_q;
    sts_o.mode      = scc_pkg::mode_e'(mode_q);
    sts_o.last_atom = CW'(idx_q) == (loaded_q - CW'(1));
    sts_o.empty     = loaded_q == '0;
    sts_o.cnt_zero  = cnt_q == '0;
    sts_o.div_done  = div_done;
  end

endmodule

[hdl/scc_ctrl.sv]
// Controller state machine: sequences loads and the per-atom query walk.
// Depends on scc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  scc_pkg::op_e         op_i,
  input  scc_pkg::sts_t        sts_i,
  output scc_pkg::cmd_t        cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  scc_pkg::ctrl_state_e state_q, state_d;
  logic                 done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scc_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_d  = 1'b0;
    case (state_q)
      scc_pkg::S_IDLE: begin
        if (start_i) begin
          if (op_i == scc_pkg::OP_LOAD) begin
            cmd_o.load_atom = 1'b1;
          end else begin
            cmd_o.latch_vtx = 1'b1;
            state_d = sts_i.empty ? scc_pkg::S_SATURATE : scc_pkg::S_FETCH;
          end
        end
      end
      scc_pkg::S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_d = scc_pkg::S_SQUARE;
      end
      scc_pkg::S_SQUARE: begin
        cmd_o.sq_en = 1'b1;
        state_d = scc_pkg::S_CHECK;
      end
      scc_pkg::S_CHECK: begin
        cmd_o.cmp_en = 1'b1;
        state_d = scc_pkg::S_DECIDE;
      end
      scc_pkg::S_DECIDE: begin
        state_d = scc_pkg::S_NEXT;
        if (sts_i.in_range) begin
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.mode == scc_pkg::MODE_AVG) begin
            cmd_o.acc_charge = 1'b1;
          end else begin
            cmd_o.prod_en = 1'b1;
            state_d = scc_pkg::S_TSTART;
          end
        end
      end
      scc_pkg::S_TSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = scc_pkg::S_TDIV;
      end
      scc_pkg::S_TDIV: begin
        if (sts_i.div_done) begin
          cmd_o.exp1_en = 1'b1;
          state_d = scc_pkg::S_EXPK;
        end
      end
      scc_pkg::S_EXPK: begin
        cmd_o.exp2_en = 1'b1;
        state_d = scc_pkg::S_EMUL;
      end
      scc_pkg::S_EMUL: begin
        cmd_o.exp3_en = 1'b1;
        state_d = scc_pkg::S_ACCUM;
      end
      scc_pkg::S_ACCUM: begin
        cmd_o.acc_term = 1'b1;
        state_d = scc_pkg::S_NEXT;
      end
      scc_pkg::S_NEXT: begin
        if (!sts_i.last_atom) begin
          cmd_o.idx_inc = 1'b1;
          state_d = scc_pkg::S_FETCH;
        end else if (sts_i.mode == scc_pkg::MODE_AVG && !sts_i.cnt_zero) begin
          state_d = scc_pkg::S_AVG_START;
        end else begin
          state_d = scc_pkg::S_SATURATE;
        end
      end
      scc_pkg::S_AVG_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_avg   = 1'b1;
        state_d = scc_pkg::S_AVG_DIV;
      end
      scc_pkg::S_AVG_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.avg_take = 1'b1;
          state_d = scc_pkg::S_SATURATE;
        end
      end
      scc_pkg::S_SATURATE: begin
        cmd_o.sat_en = 1'b1;
        state_d = scc_pkg::S_COLOR;
      end
      scc_pkg::S_COLOR: begin
        cmd_o.out_en = 1'b1;
        done_d  = 1'b1;
        state_d = scc_pkg::S_IDLE;
      end
      default: begin
        state_d = scc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = state_q != scc_pkg::S_IDLE;
  assign done_o = done_q;

  // Checks
  `ASSERT_NEXT(a_color_strobes, clk_i, rst_ni, state_q == scc_pkg::S_COLOR, done_q)
  `ASSERT_ALWAYS(a_strobe_when_idle, clk_i, rst_ni, !done_q || state_q == scc_pkg::S_IDLE)
  `ASSERT_ALWAYS(a_no_step_past_last, clk_i, rst_ni, !(cmd_o.idx_inc && sts_i.last_atom))
  `ASSERT_NEXT(a_query_goes_busy, clk_i, rst_ni, start_i && !busy_o && op_i == scc_pkg::OP_QUERY, busy_o)

endmodule

[dv/scc_checker.sv]
// Checker for the surface charge colorizer: watches the command, result and
// register channels, predicts each vertex result and compares it. Needs scc_pkg.
`timescale 1ns / 1ps

module scc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  scc_pkg::in_item_t              in_i,
  input  logic                           done_o,
  input  scc_pkg::out_item_t             result_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             accepted_o,
  output int                             cfg_writes_o
);
  import scc_pkg::*;

  localparam int ATOM_CAP   = MAX_ATOMS_DEF;
  localparam int TABLE_SIZE = EXP_TABLE_DEPTH_DEF;

  longint    atom_x [ATOM_CAP];
  longint    atom_y [ATOM_CAP];
  longint    atom_z [ATOM_CAP];
  longint    atom_r [ATOM_CAP];
  longint    atom_q [ATOM_CAP];
  int        atom_count;
  mode_e     cur_mode;
  longint    cur_cutoff;
  longint    cur_blob;
  longint    pow2_frac [TABLE_SIZE];
  out_item_t vertex_queue [$];

  // Build 2^(k/depth) in Q.16 through a power series of k*ln2/depth in Q.30
  initial begin
    longint unsigned x, acc, term;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      x    = (longint'(k) * longint'(LN2_Q30)) / TABLE_SIZE;
      acc  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int i = 1; i <= 30; i++) begin
        term = ((term * x) >> 30) / longint'(i);
        acc  = acc + term;
      end
      pow2_frac[k] = longint'((acc + 64'd8192) >> 14);
    end
  end

  // Gaussian contribution of one neighbor, in Q.12
  function automatic longint blob_term(longint q, longint d2, longint radius);
    longint r, r2, t, u, n, f, k, e;
    r  = (radius == 0) ? 1 : radius;
    r2 = r * r;
    t  = (cur_blob * (d2 - r2)) / r2;
    if (t > T_LIMIT) t = T_LIMIT;
    if (t < -T_LIMIT) t = -T_LIMIT;
    u = (t * LOG2E_Q16) >>> 12;
    n = u >>> 16;
    f = u - n * 65536;
    k = (f * TABLE_SIZE) >>> 16;
    if (n > 23) begin
      n = 23;
      k = TABLE_SIZE - 1;
    end
    if (n < -32) return 0;
    if (k >= TABLE_SIZE) k = TABLE_SIZE - 1;
    e = pow2_frac[k];
    if (n >= 0) e = e << n;
    else e = e >> (-n);
    return (q * e) >>> 16;
  endfunction

  function automatic logic [7:0] color_level(longint mag, inout logic sat);
    if (mag > 8192) begin
      sat = 1'b1;
      return 8'd0;
    end
    return 8'((255 * (8192 - mag) + 4096) >> 13);
  endfunction

  // Charge and color seen at one surface vertex
  function automatic out_item_t vertex_color(longint vx, longint vy, longint vz);
    out_item_t res;
    longint    dx, dy, dz, d2, cut2, acc, mag;
    int        hits;
    logic      sat;
    cut2 = cur_cutoff * cur_cutoff;
    acc  = 0;
    hits = 0;
    sat  = 1'b0;
    for (int i = 0; i < atom_count; i++) begin
      dx = vx - atom_x[i];
      dy = vy - atom_y[i];
      dz = vz - atom_z[i];
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 <= cut2) begin
        hits++;
        if (cur_mode == MODE_AVG) acc += atom_q[i];
        else acc += blob_term(atom_q[i], d2, atom_r[i]);
      end
    end
    if (cur_mode == MODE_AVG && hits > 0) acc = acc / hits;
    if (acc > CHARGE_MAX) begin
      acc = CHARGE_MAX;
      sat = 1'b1;
    end
    if (acc < CHARGE_MIN) begin
      acc = CHARGE_MIN;
      sat = 1'b1;
    end
    mag = (acc < 0) ? -acc : acc;
    res.red   = 8'd255;
    res.green = 8'd255;
    res.blue  = 8'd255;
    if (acc < 0) begin
      res.green = color_level(mag, sat);
      res.blue  = res.green;
    end else if (acc > 0) begin
      res.red   = color_level(mag, sat);
      res.green = res.red;
    end
    res.vertex_charge  = 24'(acc);
    res.neighbor_count = CNT_OUT_W'(hits);
    res.saturated      = sat;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Compare results, then record register writes and accepted transactions
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      atom_count   = 0;
      cur_mode     = MODE_GAUSS;
      cur_cutoff   = 2560;
      cur_blob     = -8192;
      fail_count_o = 0;
      accepted_o   = 0;
      cfg_writes_o = 0;
      vertex_queue.delete();
      pending_o    = 0;
    end else begin
      if (done_o) begin
        if (vertex_queue.size() == 0) begin
          report("unexpected result, charge", result_o.vertex_charge, 0);
        end else begin
          want = vertex_queue.pop_front();
          if (result_o.vertex_charge !== want.vertex_charge)
            report("vertex_charge", result_o.vertex_charge, want.vertex_charge);
          if (result_o.red !== want.red) report("red", result_o.red, want.red);
          if (result_o.green !== want.green) report("green", result_o.green, want.green);
          if (result_o.blue !== want.blue) report("blue", result_o.blue, want.blue);
          if (result_o.neighbor_count !== want.neighbor_count)
            report("neighbor_count", result_o.neighbor_count, want.neighbor_count);
          if (result_o.saturated !== want.saturated)
            report("saturated", result_o.saturated, want.saturated);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODE:   cur_mode = mode_e'(cfg_data_i[0]);
          CFG_CUTOFF: cur_cutoff = longint'(cfg_data_i);
          CFG_BLOB:   cur_blob = longint'($signed(cfg_data_i));
          default: ;
        endcase
        cfg_writes_o++;
      end
      if (start && !busy) begin
        if (in_i.operation == OP_QUERY) begin
          vertex_queue.push_back(vertex_color(in_i.pos_x, in_i.pos_y, in_i.pos_z));
        end else if (atom_count < ATOM_CAP) begin
          atom_x[atom_count] = in_i.pos_x;
          atom_y[atom_count] = in_i.pos_y;
          atom_z[atom_count] = in_i.pos_z;
          atom_r[atom_count] = longint'(in_i.atom_radius);
          atom_q[atom_count] = in_i.atom_charge;
          atom_count++;
        end
        accepted_o++;
      end
      pending_o = vertex_queue.size();
    end
  end

endmodule

[dv/surface_charge_colorizer_tb.sv]
// Testbench top for the surface charge colorizer: clock, reset, atom loads,
// vertex queries and register writes; checking is done by scc_checker.
`timescale 1ns / 1ps

module surface_charge_colorizer_tb;
  import scc_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  in_item_t              in_i;
  logic                  done_o;
  out_item_t             result_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;
  int                    accepted;
  int                    cfg_writes;
  int                    idle_pct;

  surface_charge_colorizer i_dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .done_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  scc_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .in_i, .done_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .accepted_o(accepted), .cfg_writes_o(cfg_writes)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop for a hung block
  initial begin
    #6000000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_item_t make_item(op_e op, int x, int y, int z, int r, int q);
    in_item_t it;
    it.operation   = op;
    it.pos_x       = COORD_W'(x);
    it.pos_y       = COORD_W'(y);
    it.pos_z       = COORD_W'(z);
    it.atom_radius = RAD_W'(r);
    it.atom_charge = CHG_W'(q);
    return it;
  endfunction

  // Offer one transaction after random idle cycles; returns at a falling edge
  task automatic send(in_item_t it);
    int seen;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    seen = accepted;
    do @(negedge clk_i); while (accepted == seen);
  endtask

  // Wait out every expected vertex result, then the tail of a load
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    int seen;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    seen = cfg_writes;
    do @(negedge clk_i); while (cfg_writes == seen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(mode_e m, int cutoff, int blob);
    write_reg(CFG_MODE, m);
    write_reg(CFG_CUTOFF, cutoff);
    write_reg(CFG_BLOB, blob);
  endtask

  function automatic int near_coord();
    return $urandom_range(4000) - 2000;
  endfunction

  // Mostly clustered atoms and vertices, some full-range noise
  task automatic random_phase(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
      end else begin
        it = make_item($urandom_range(99) < 35 ? OP_LOAD : OP_QUERY,
                       near_coord(), near_coord(), near_coord(),
                       $urandom_range(1024, 64), $urandom);
      end
      if (it.operation == OP_LOAD && it.atom_radius == 0) it.atom_radius = 1;
      if ($urandom_range(99) < 5) drain();
      send(it);
    end
  endtask

  initial begin
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i  = '0;
    idle_pct    = 0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty store gives no neighbors
    send(make_item(OP_QUERY, 0, 0, 0, 0, 0));
    // Extreme atoms, zero radius and extreme charges
    send(make_item(OP_LOAD, 0, 0, 0, 256, 4096));
    send(make_item(OP_LOAD, 256, 0, 0, 0, -32768));
    send(make_item(OP_LOAD, 0, 512, 0, 4095, 32767));
    send(make_item(OP_LOAD, -8388608, -8388608, -8388608, 1, -4096));
    send(make_item(OP_LOAD, 8388607, 8388607, 8388607, 4095, 12000));
    send(make_item(OP_QUERY, 0, 0, 0, 4095, -1));
    send(make_item(OP_QUERY, 256, 0, 0, 0, 0));
    send(make_item(OP_QUERY, -8388608, -8388608, -8388608, 0, 0));
    send(make_item(OP_QUERY, 8388607, 8388607, 8388607, 0, 0));
    // Average mode over near and far vertices
    set_regs(MODE_AVG, 2560, -8192);
    send(make_item(OP_QUERY, 128, 0, 0, 0, 0));
    send(make_item(OP_QUERY, 8388607, 8388607, 8388607, 0, 0));
    // Large exponent: charge and colors saturate
    set_regs(MODE_GAUSS, 65535, 32767);
    send(make_item(OP_QUERY, 0, 2560, 0, 0, 0));
    send(make_item(OP_QUERY, 256, 0, 2000, 0, 0));
    // Small exponent: distant neighbors add nothing
    write_reg(CFG_BLOB, -32768);
    send(make_item(OP_QUERY, 0, -5000, 0, 0, 0));
    // Zero cutoff keeps only exact hits
    write_reg(CFG_CUTOFF, 0);
    send(make_item(OP_QUERY, 256, 0, 0, 0, 0));
    send(make_item(OP_QUERY, 1, 0, 0, 0, 0));

    // Random phases under different idling and register settings
    drain();
    set_regs(MODE_GAUSS, 2560, -8192);
    idle_pct = 0;
    random_phase(28);
    set_regs(mode_e'($urandom_range(1)), $urandom_range(4000, 500), $urandom);
    idle_pct = 71;
    random_phase(28);
    set_regs(MODE_AVG, $urandom_range(65535), $urandom);
    idle_pct = 37;
    random_phase(28);
    set_regs(MODE_GAUSS, $urandom_range(3000, 300), $urandom_range(8191) - 4096);
    idle_pct = 0;
    random_phase(28);

    // Load a cluster of far atoms, then query it in both modes
    drain();
    set_regs(MODE_GAUSS, 2560, -8192);
    for (int i = 0; i < 8; i++)
      send(make_item(OP_LOAD, 8000000, $urandom_range(1000), 0, 200, $urandom));
    send(make_item(OP_QUERY, 0, 0, 0, 0, 0));
    send(make_item(OP_QUERY, 8000000, 500, 0, 0, 0));
    write_reg(CFG_MODE, MODE_AVG);
    send(make_item(OP_QUERY, 8000000, 500, 0, 0, 0));

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
